>>> src/sws_pkg.sv
// sws_pkg: shared types, widths and constants for sensor_window_statistics
// no dependencies
`default_nettype none
package sws_pkg;
    localparam int LevelW = 20;
    localparam int SampleW = 12;
    localparam int AlphaW = 16;
    localparam int SlopeW = 21;
    localparam int CountW = 7;
    localparam int WindowDef = 64;
    localparam logic [AlphaW-1:0] AlphaReset = 16'd13107;
    localparam logic signed [SlopeW-1:0] SlopeMax = 21'sd1048575;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_STORE,
        ST_SCAN,
        ST_SCAN_ACC,
        ST_PREP,
        ST_DIV,
        ST_DIFF,
        ST_OUT
    } sws_state_t;

    // serial divider / root control
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } sws_op_t;
endpackage
`default_nettype wire

>>> src/sws_serial_unit.sv
// sws_serial_unit: bit-serial restoring divider and integer square root
// depends on sws_pkg
`default_nettype none
module sws_serial_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sws_pkg::sws_op_t op,
    input  wire logic [95:0]   num,
    input  wire logic [95:0]   den,
    output logic               busy,
    output logic [95:0]        res
);
    logic [95:0] rem_reg, rem_next, quo_reg, quo_next, numsh_reg, numsh_next, den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        sq_reg, run_reg, run_next;
    logic [96:0] trial;
    logic [97:0] strial;
    logic [97:0] srem;

    assign busy = run_reg;
    assign res  = quo_reg;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        numsh_next = numsh_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        trial = '0;
        srem = '0;
        strial = '0;
        if (op.start) begin
            rem_next = '0;
            quo_next = '0;
            numsh_next = num;
            run_next = 1'b1;
            cnt_next = op.is_sqrt ? 7'd48 : 7'd96;
        end else if (run_reg) begin
            if (sq_reg) begin
                // two numerator bits per step, trial 4q+1
                srem = {rem_reg, numsh_reg[95:94]};
                strial = {quo_reg, 2'b01};
                numsh_next = {numsh_reg[93:0], 2'b00};
                if (srem >= strial) begin
                    rem_next = 96'(srem - strial);
                    quo_next = {quo_reg[94:0], 1'b1};
                end else begin
                    rem_next = srem[95:0];
                    quo_next = {quo_reg[94:0], 1'b0};
                end
            end else begin
                trial = {rem_reg, numsh_reg[95]};
                numsh_next = {numsh_reg[94:0], 1'b0};
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = 96'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[94:0], 1'b1};
                end else begin
                    rem_next = trial[95:0];
                    quo_next = {quo_reg[94:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        numsh_reg <= numsh_next;
        if (op.start) begin
            den_reg <= den;
            sq_reg <= op.is_sqrt;
        end
    end
endmodule
`default_nettype wire

>>> src/sensor_window_statistics.sv
// sensor_window_statistics: low-pass filter, sample window and serial statistics
// depends on sws_pkg and sws_serial_unit
//
// Each item filters one 12-bit sample into a 12.8 level (a 16-bit serial
// multiply-accumulate) and stores it in a WINDOW-entry memory. With a report the
// window is read one entry at a time (a read state, then an accumulate state),
// the sums are combined in a prepare state and a difference state, and then the
// shared bit-serial unit runs four divisions and two square roots. The input is
// taken only while the block is idle; a finished result that is still waiting
// only holds the next report at its output stage.
`default_nettype none
module sensor_window_statistics #(
    parameter int WINDOW = sws_pkg::WindowDef
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample[11:0], zero fill
    input  wire logic        s_tuser,   // report
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [127:0]     m_tdata    // mean, std_dev, rms, min, max (20 each), slope 21, count 7
);
    localparam int PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FillW = $clog2(WINDOW + 1);

    sws_pkg::sws_state_t state_reg, state_next;
    logic [15:0] alpha_reg;
    logic [19:0] level_reg;
    logic        first_reg, report_reg;
    logic [11:0] sample_reg;
    logic [PtrW-1:0]  wptr_reg;
    logic [FillW-1:0] fill_reg;
    logic [19:0] mem [WINDOW];
    logic [19:0] rd_reg;
    logic [PtrW-1:0] rptr_reg;
    logic [FillW-1:0] idx_reg;
    logic [4:0]  bit_reg;
    logic [37:0] macc_reg;   // level*(65536-a) + a*s8, serially
    logic [16:0] mulb_reg;
    // window sums, sized for WINDOW up to 256
    logic [31:0] s_reg;
    logic [47:0] q_reg;
    logic [35:0] sxy_reg;
    logic [15:0] sx_reg;
    logic [23:0] sxx_reg;
    logic [19:0] lo_reg, hi_reg;
    logic [2:0]  step_reg;
    logic [95:0] num, den;
    sws_pkg::sws_op_t op;
    logic        busy;
    logic [95:0] res;
    logic [19:0] mean_reg, sd_reg, rms_reg;
    logic signed [20:0] slope_reg;
    logic        neg_reg;
    logic [63:0] nq_reg, ss_reg, pa_reg, pb_reg;
    logic [31:0] nsxx_reg, sxsq_reg;
    logic [17:0] nsq_reg;
    logic [95:0] snum_reg, sden_reg, var_reg;
    logic [127:0] out_reg;
    logic        ovalid_reg, started_reg, out_load;
    logic [39:0] rd_sq;
    logic [28:0] idx_rd;
    logic [17:0] idx_sq;
    logic [FillW-1:0] fill_new;
    logic [31:0] start_sum;
    logic [PtrW-1:0] start_pos;

    logic [FillW-1:0] n;
    assign n = fill_reg;

    assign s_tready = (state_reg == sws_pkg::ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;
    assign out_load = (state_reg == sws_pkg::ST_OUT) && (!ovalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sws_pkg::ST_IDLE:     if (s_tvalid && s_tready) state_next = sws_pkg::ST_FILT;
            sws_pkg::ST_FILT:     if (bit_reg == 5'd16) state_next = sws_pkg::ST_STORE;
            sws_pkg::ST_STORE:    state_next = report_reg ? sws_pkg::ST_SCAN : sws_pkg::ST_IDLE;
            sws_pkg::ST_SCAN:     state_next = sws_pkg::ST_SCAN_ACC;
            sws_pkg::ST_SCAN_ACC: state_next = (idx_reg == n - FillW'(1)) ? sws_pkg::ST_PREP
                                                                          : sws_pkg::ST_SCAN;
            sws_pkg::ST_PREP:     state_next = sws_pkg::ST_DIFF;
            sws_pkg::ST_DIFF:     state_next = sws_pkg::ST_DIV;
            sws_pkg::ST_DIV:      if (started_reg && !busy) begin
                                      state_next = (step_reg == 3'd5) ? sws_pkg::ST_OUT
                                                                      : sws_pkg::ST_DIV;
                                  end
            sws_pkg::ST_OUT:      if (out_load) state_next = sws_pkg::ST_IDLE;
            default:              state_next = sws_pkg::ST_IDLE;
        endcase
    end

    // step sequence: 0 mean, 1 var=(nq-s^2)/n^2, 2 sqrt var, 3 q/n, 4 sqrt, 5 slope
    always_comb begin
        op = '0;
        num = '0;
        den = '0;
        if (state_reg == sws_pkg::ST_DIV && !started_reg) begin
            op.start = 1'b1;
            case (step_reg)
                3'd0: begin num = 96'(s_reg); den = 96'(n); end
                3'd1: begin num = var_reg; den = 96'(nsq_reg); end
                3'd2: begin num = res; op.is_sqrt = 1'b1; end
                3'd3: begin num = 96'(q_reg); den = 96'(n); end
                3'd4: begin num = res; op.is_sqrt = 1'b1; end
                3'd5: begin num = snum_reg; den = sden_reg; end
                default: ;
            endcase
        end
    end

    // per-entry terms of the scan
    assign rd_sq  = 40'(rd_reg) * 40'(rd_reg);
    assign idx_rd = 29'(idx_reg) * 29'(rd_reg);
    assign idx_sq = 18'(idx_reg) * 18'(idx_reg);

    // oldest valid entry once the new level is stored
    assign fill_new  = (fill_reg == FillW'(WINDOW)) ? fill_reg : fill_reg + 1'b1;
    assign start_sum = 32'(wptr_reg) + 32'(WINDOW) + 32'd1 - 32'(fill_new);
    assign start_pos = (start_sum >= 32'(WINDOW)) ? PtrW'(start_sum - 32'(WINDOW))
                                                  : PtrW'(start_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sws_pkg::ST_IDLE;
            alpha_reg <= sws_pkg::AlphaReset;
            first_reg <= 1'b1;
            level_reg <= '0;
            wptr_reg <= '0;
            fill_reg <= '0;
            ovalid_reg <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) alpha_reg <= cfg_wr_data;
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                sws_pkg::ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        sample_reg <= s_tdata[11:0];
                        report_reg <= s_tuser;
                        bit_reg <= '0;
                        macc_reg <= '0;
                        mulb_reg <= 17'h10000 - {1'b0, alpha_reg};
                    end
                end
                sws_pkg::ST_FILT: begin
                    // one bit of (65536-a) and of a per cycle
                    if (bit_reg != 5'd16 || mulb_reg[0]) begin
                        macc_reg <= macc_reg
                            + (mulb_reg[0] ? (38'(level_reg) << bit_reg) : 38'd0)
                            + ((bit_reg < 5'd16 && alpha_reg[bit_reg[3:0]])
                               ? (38'({sample_reg, 8'd0}) << bit_reg) : 38'd0);
                    end
                    mulb_reg <= mulb_reg >> 1;
                    bit_reg <= bit_reg + 5'd1;
                end
                sws_pkg::ST_STORE: begin
                    logic [19:0] nl;
                    nl = first_reg ? {sample_reg, 8'd0} : macc_reg[35:16];
                    level_reg <= nl;
                    first_reg <= 1'b0;
                    mem[wptr_reg] <= nl;
                    wptr_reg <= (wptr_reg == PtrW'(WINDOW - 1)) ? '0 : wptr_reg + 1'b1;
                    if (fill_reg != FillW'(WINDOW)) fill_reg <= fill_reg + 1'b1;
                    idx_reg <= '0;
                    s_reg <= '0; q_reg <= '0; sxy_reg <= '0;
                    sx_reg <= '0; sxx_reg <= '0;
                    lo_reg <= 20'hFFFFF; hi_reg <= '0;
                    rptr_reg <= start_pos;
                end
                sws_pkg::ST_SCAN: begin
                    rd_reg <= mem[rptr_reg];
                    rptr_reg <= (rptr_reg == PtrW'(WINDOW - 1)) ? '0 : rptr_reg + 1'b1;
                end
                sws_pkg::ST_SCAN_ACC: begin
                    s_reg <= s_reg + 32'(rd_reg);
                    q_reg <= q_reg + 48'(rd_sq);
                    sxy_reg <= sxy_reg + 36'(idx_rd);
                    sx_reg <= sx_reg + 16'(idx_reg);
                    sxx_reg <= sxx_reg + 24'(idx_sq);
                    if (rd_reg < lo_reg) lo_reg <= rd_reg;
                    if (rd_reg > hi_reg) hi_reg <= rd_reg;
                    idx_reg <= idx_reg + 1'b1;
                end
                sws_pkg::ST_PREP: begin
                    nq_reg <= 64'(n) * 64'(q_reg);
                    ss_reg <= 64'(s_reg) * 64'(s_reg);
                    pa_reg <= 64'(n) * 64'(sxy_reg);
                    pb_reg <= 64'(sx_reg) * 64'(s_reg);
                    nsxx_reg <= 32'(n) * 32'(sxx_reg);
                    sxsq_reg <= 32'(sx_reg) * 32'(sx_reg);
                    nsq_reg <= 18'(n) * 18'(n);
                    step_reg <= '0;
                    started_reg <= 1'b0;
                end
                sws_pkg::ST_DIFF: begin
                    var_reg <= (nq_reg > ss_reg) ? 96'(nq_reg - ss_reg) : '0;
                    neg_reg <= pb_reg > pa_reg;
                    snum_reg <= (pb_reg > pa_reg) ? 96'(pb_reg - pa_reg) : 96'(pa_reg - pb_reg);
                    sden_reg <= 96'(nsxx_reg - sxsq_reg);
                end
                sws_pkg::ST_DIV: begin
                    if (!started_reg) begin
                        started_reg <= 1'b1;
                    end else if (!busy) begin
                        started_reg <= 1'b0;
                        step_reg <= step_reg + 3'd1;
                        case (step_reg)
                            3'd0: mean_reg <= res[19:0];
                            3'd2: sd_reg <= res[19:0];
                            3'd4: rms_reg <= res[19:0];
                            3'd5: begin
                                if (n < FillW'(2) || sden_reg == '0) slope_reg <= '0;
                                else if (res > 96'd1048575)
                                    slope_reg <= neg_reg ? -sws_pkg::SlopeMax
                                                         : sws_pkg::SlopeMax;
                                else slope_reg <= neg_reg ? -$signed({1'b0, res[19:0]})
                                                          : $signed({1'b0, res[19:0]});
                            end
                            default: ;
                        endcase
                    end
                end
                sws_pkg::ST_OUT: begin
                    if (out_load) begin
                        out_reg <= {7'(n), slope_reg, hi_reg, lo_reg, rms_reg, sd_reg, mean_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    sws_serial_unit u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .num     (num),
        .den     (den),
        .busy    (busy),
        .res     (res)
    );

    logic unused;
    assign unused = ^{s_tdata[15:12]};
endmodule
`default_nettype wire

>>> tb/sv/tb_sensor_window_statistics.sv
// tb_sensor_window_statistics: stream testbench for sensor_window_statistics with
// its own filter and window-statistics predictor, directed and random items
// depends on sws_pkg and the sensor_window_statistics rtl
`default_nettype none
module tb_sensor_window_statistics;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Win = sws_pkg::WindowDef;
    localparam int ReportCycles = 2 * Win + 600;
    localparam int PlainCycles = 40;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;   // sample[11:0], zero fill
    logic s_tuser = 1'b0;        // report
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;       // mean, std_dev, rms, min, max (20 each), slope 21, count 7

    sensor_window_statistics dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [sws_pkg::AlphaW-1:0] alpha_reg = sws_pkg::AlphaReset;
    logic [sws_pkg::LevelW-1:0] level = '0;
    bit seed_pending = 1'b1;
    logic [sws_pkg::LevelW-1:0] level_hist [Win];
    int hist_ptr = 0;
    int hist_fill = 0;

    logic [127:0] stats_due [$];
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    bit failed = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [127:0] window_stats();
        longint unsigned n, s, q, sxy, a, b, v, mean_v, sd_v, rms_v;
        longint sx, sxx, num, den, slp;
        logic [sws_pkg::LevelW-1:0] lo, hi, y;
        int start;
        n = hist_fill;
        s = 0; q = 0; sxy = 0; v = 0; slp = 0;
        lo = '1; hi = '0;
        start = (hist_ptr + Win - hist_fill) % Win;
        for (int i = 0; i < hist_fill; i++) begin
            y = level_hist[(start + i) % Win];
            s += y;
            q += longint'(y) * y;
            sxy += longint'(i) * y;
            if (y < lo) lo = y;
            if (y > hi) hi = y;
        end
        a = n * q;
        b = s * s;
        if (a > b) v = (a - b) / (n * n);
        if (n >= 2) begin
            sx = n * (n - 1) / 2;
            sxx = (n - 1) * n * (2 * n - 1) / 6;
            num = longint'(n) * longint'(sxy) - sx * longint'(s);
            den = longint'(n) * sxx - sx * sx;
            if (den > 0) slp = num / den;
            if (slp > sws_pkg::SlopeMax) slp = sws_pkg::SlopeMax;
            if (slp < -longint'(sws_pkg::SlopeMax)) slp = -longint'(sws_pkg::SlopeMax);
        end
        mean_v = s / n;
        sd_v = int_sqrt(v);
        rms_v = int_sqrt(q / n);
        return {n[6:0], slp[20:0], hi, lo, rms_v[19:0], sd_v[19:0], mean_v[19:0]};
    endfunction

    // absorb one accepted item into the predicted filter and window
    task automatic absorb_item(logic [sws_pkg::SampleW-1:0] smp, bit rep);
        longint unsigned acc;
        if (seed_pending) begin
            level = {smp, 8'd0};
            seed_pending = 1'b0;
        end else begin
            acc = longint'(level) * (65536 - alpha_reg) + longint'(alpha_reg) * {smp, 8'd0};
            level = acc[35:16];
        end
        level_hist[hist_ptr] = level;
        hist_ptr = (hist_ptr + 1) % Win;
        if (hist_fill < Win) hist_fill++;
        if (rep) stats_due.push_back(window_stats());
    endtask

    task automatic send_item(logic [sws_pkg::SampleW-1:0] smp, bit rep);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, smp};
        s_tuser <= rep;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_item(smp, rep);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (PlainCycles) @(posedge aclk);
    endtask

    task automatic write_alpha(logic [sws_pkg::AlphaW-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        alpha_reg = val;
    endtask

    // receiver stalls
    always @(posedge aclk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    localparam int FieldLo [7] = '{0, 20, 40, 60, 80, 100, 121};
    localparam int FieldW [7] = '{20, 20, 20, 20, 20, 21, 7};
    localparam string FieldName [7] =
        '{"mean_level", "std_dev", "rms_level", "min_level", "max_level", "slope",
          "entry_count"};

    always @(posedge aclk) begin
        logic [127:0] want;
        longint unsigned w, g;
        if (aresetn && m_tvalid && m_tready) begin
            if (stats_due.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                failed = 1'b1;
            end else begin
                want = stats_due.pop_front();
                for (int f = 0; f < 7; f++) begin
                    w = 64'((want >> FieldLo[f]) & ((128'd1 << FieldW[f]) - 1));
                    g = 64'((m_tdata >> FieldLo[f]) & ((128'd1 << FieldW[f]) - 1));
                    if (w != g) begin
                        $display("%0t: %s expected %h actual %h", $realtime,
                                 FieldName[f], w, g);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // first sample seeds the level, a one-entry window gives zero slope
    task automatic test_first_sample();
        send_item(12'hABC, 1'b1);
        send_item(12'h000, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_item(12'hFFF, 1'b0);
        send_item(12'hFFF, 1'b1);
        send_item(12'h000, 1'b0);
        send_item(12'h000, 1'b1);
        send_item(12'h555, 1'b1);
        send_item(12'hAAA, 1'b1);
    endtask

    // alpha zero holds the level, alpha full follows the sample almost at once
    task automatic test_alpha_extremes();
        write_alpha(16'd0);
        send_item(12'hFFF, 1'b1);
        send_item(12'h123, 1'b1);
        write_alpha(16'hFFFF);
        for (int i = 0; i < 6; i++) send_item(i[0] ? 12'hFFF : 12'h000, i >= 4);
        write_alpha(16'd1);
        send_item(12'hFFF, 1'b1);
    endtask

    task automatic test_random_phase(int items, int gap_pct, int stall_pct);
        int mode;
        logic [sws_pkg::SampleW-1:0] smp;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        mode = int'($urandom_range(2));
        if (mode == 0) write_alpha(16'($urandom));
        else if (mode == 1) write_alpha(16'($urandom_range(65535, 60000)));
        else write_alpha(16'($urandom_range(200)));
        for (int i = 0; i < items; i++) begin
            // half noise, half ramps, to exercise the slope
            case ($urandom_range(3))
                0: smp = 12'(i * 40);
                1: smp = 12'(4095 - i * 40);
                default: smp = 12'($urandom);
            endcase
            send_item(smp, $urandom_range(5) == 0);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_sample();
        test_field_extremes();
        test_alpha_extremes();
        test_random_phase(510, 12, 48);
        test_random_phase(510, 48, 12);
        test_random_phase(510, 0, 0);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (ReportCycles) @(posedge aclk);
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #80ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

>>> sensor_window_statistics.f
src/sws_pkg.sv
src/sws_serial_unit.sv
src/sensor_window_statistics.sv
tb/sv/tb_sensor_window_statistics.sv
